@@ src/srq_pkg.sv @@
// ----------------------------------------------------------------------------
// srq_pkg
// Shared constants, types and helpers of the sequenced ring queue.
// ----------------------------------------------------------------------------
package srq_pkg;

    localparam int MAX_DEPTH = 64;
    localparam int ADDR_W    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    // largest power of two not above the maximum depth
    localparam int CAP_LIMIT = 1 << ($clog2(MAX_DEPTH + 1) - 1);

    localparam int DATA_W   = 64;
    localparam int SEQ_W    = 32;
    localparam int CAP_W    = 7;
    localparam int CNT_W    = 7;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 3;
    localparam int OUT_TDATA_W = ((DATA_W + CNT_W + 1 + 7) / 8) * 8;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    typedef enum logic [FUNC_W-1:0] {
        FN_ENQ    = 2'd0,
        FN_DEQ    = 2'd1,
        FN_REINIT = 2'd2,
        FN_CLOSE  = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_INVALID      = 3'd1,
        ST_FULL         = 3'd2,
        ST_EMPTY        = 3'd3,
        ST_DISCONNECTED = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_cell_rd;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [SEQ_W-1:0]  seq;
        logic [DATA_W-1:0] data;
    } t_cell_wr;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [DATA_W-1:0] data;
    } t_cell;

    // Round a requested depth up to a power of two, capped at CAP_LIMIT.
    function automatic logic [CAP_W-1:0] round_capacity(input logic [CAP_W-1:0] req);
        logic [CAP_W-1:0] p;
        p = CAP_W'(1);
        for (int k = 0; k < CAP_W; k++) begin
            if ((p < req) && (p < CAP_W'(CAP_LIMIT))) begin
                p = p << 1;
            end
        end
        return p;
    endfunction

endpackage

@@ src/sequenced_ring_queue_core.sv @@
// ----------------------------------------------------------------------------
// sequenced_ring_queue_core
// Bounded FIFO of 64-bit words in a ring of sequence-numbered cells.
// ----------------------------------------------------------------------------
// Flow: an accepted transaction is held while its cell is read; its result
// enters the output register once that register can take it, and leaves on
// the first cycle that m_axis_tready is high. A new transaction is taken only
// after the last one's read, update and write-back of the cell memory.
// Reset (i_rst_n low, synchronous) opens an empty queue of depth 64; cells
// read as their initial values through valid bits, so no clearing pass.
// ----------------------------------------------------------------------------
module sequenced_ring_queue_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // capacity request register
    input  logic                                 i_cfg_we,
    input  logic [srq_pkg::CAP_W-1:0]            i_cfg_wdata,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [srq_pkg::DATA_W-1:0]           s_axis_tdata,  // [63:0] data_in
    input  logic [srq_pkg::FUNC_W-1:0]           s_axis_tuser,  // [1:0] func
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [63:0] data_out, [70:64] length, [71] is_full
    output logic [srq_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic [srq_pkg::STATUS_W-1:0]         m_axis_tuser   // [2:0] status
);
    import srq_pkg::*;

    // ---------------------------------------------------------------- state
    t_state            r_state, n_state;
    logic [CAP_W-1:0]  r_cap_req;
    logic [CAP_W-1:0]  r_cap, n_cap;
    logic [SEQ_W-1:0]  r_wpos, n_wpos;
    logic [SEQ_W-1:0]  r_rpos, n_rpos;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_open, n_open;

    // transaction held while its cell is read
    t_func             r_func;
    logic [DATA_W-1:0] r_data_in;
    logic [ADDR_W-1:0] r_idx;

    // output register
    logic              r_out_valid;
    t_status           r_out_status;
    logic [DATA_W-1:0] r_out_data;
    logic [CNT_W-1:0]  r_out_len;
    logic              r_out_full;

    logic              in_fire;
    logic              exec_fire;
    logic [ADDR_W-1:0] rd_idx;
    logic [ADDR_W-1:0] mask;
    t_cell_rd          cell_rd;
    t_cell_wr          cell_wr;
    t_cell             cell_q;
    logic              cell_clear;
    t_status           status;
    logic [DATA_W-1:0] result;
    logic              full;

    // ------------------------------------------------------------ cell ring
    srq_cell_store u_cells (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (cell_rd),
        .i_wr    (cell_wr),
        .i_clear (cell_clear),
        .o_cell  (cell_q)
    );

    // ---------------------------------------------------------- control FSM
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        exec_fire     = 1'b0;
        case (r_state)
            S_IDLE:  s_axis_tready = 1'b1;
            // finish only when the output register can take the result
            S_EXEC:  exec_fire = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    assign in_fire = s_axis_tvalid && s_axis_tready;

    // Issue the cell read on the accepting edge; the positions are stable
    // because no transaction is in flight while idle.
    assign mask   = ADDR_W'(r_cap - CAP_W'(1));
    assign rd_idx = ((t_func'(s_axis_tuser) == FN_DEQ) ? r_rpos[ADDR_W-1:0]
                                                       : r_wpos[ADDR_W-1:0]) & mask;
    assign cell_rd.en   = in_fire;
    assign cell_rd.addr = rd_idx;

    // ------------------------------------------------------- update logic
    always_comb begin
        n_cap      = r_cap;
        n_wpos     = r_wpos;
        n_rpos     = r_rpos;
        n_cnt      = r_cnt;
        n_open     = r_open;
        status     = ST_OK;
        result     = '0;
        cell_wr    = '0;
        cell_clear = 1'b0;
        case (r_func)
            FN_ENQ: begin
                if (!r_open) begin
                    status = ST_INVALID;
                end else if (cell_q.seq != r_wpos) begin
                    // also covers a sequence running ahead of the position
                    status = ST_FULL;
                end else begin
                    cell_wr.en   = exec_fire;
                    cell_wr.addr = r_idx;
                    cell_wr.seq  = r_wpos + SEQ_W'(1);
                    cell_wr.data = r_data_in;
                    n_wpos       = r_wpos + SEQ_W'(1);
                    n_cnt        = r_cnt + CNT_W'(1);
                end
            end
            FN_DEQ: begin
                if (!r_open) begin
                    status = ST_DISCONNECTED;
                end else if (cell_q.seq != (r_rpos + SEQ_W'(1))) begin
                    status = ST_EMPTY;
                end else begin
                    result       = cell_q.data;
                    // recycle the cell for the next lap of the writer
                    cell_wr.en   = exec_fire;
                    cell_wr.addr = r_idx;
                    cell_wr.seq  = r_rpos + SEQ_W'(r_cap);
                    cell_wr.data = cell_q.data;
                    n_rpos       = r_rpos + SEQ_W'(1);
                    n_cnt        = r_cnt - CNT_W'(1);
                end
            end
            FN_REINIT: begin
                n_cap      = round_capacity(r_cap_req);
                n_wpos     = '0;
                n_rpos     = '0;
                n_cnt      = '0;
                n_open     = 1'b1;
                cell_clear = exec_fire;
            end
            FN_CLOSE: begin
                // keep positions and cells, drop the count
                n_open = 1'b0;
                n_cnt  = '0;
            end
            default: ;
        endcase
        full = (n_cnt >= n_cap);
    end

    // ------------------------------------------------------------ registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap_req   <= CAP_RESET;
            r_cap       <= round_capacity(CAP_RESET);
            r_wpos      <= '0;
            r_rpos      <= '0;
            r_cnt       <= '0;
            r_open      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cap_req <= i_cfg_wdata;
            end
            if (exec_fire) begin
                r_cap  <= n_cap;
                r_wpos <= n_wpos;
                r_rpos <= n_rpos;
                r_cnt  <= n_cnt;
                r_open <= n_open;
            end
            if (exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the accepted transaction while its cell is read
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_func    <= t_func'(s_axis_tuser);
            r_data_in <= s_axis_tdata;
            r_idx     <= rd_idx;
        end
        if (exec_fire) begin
            r_out_status <= status;
            r_out_data   <= result;
            r_out_len    <= n_cnt;
            r_out_full   <= full;
        end
    end

    // -------------------------------------------------------------- outputs
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out_full, r_out_len, r_out_data});

endmodule

@@ src/srq_ram.sv @@
// ----------------------------------------------------------------------------
// srq_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/srq_cell_store.sv @@
// ----------------------------------------------------------------------------
// srq_cell_store
// Ring cells: sequence and data memories plus per-entry valid bits, so that
// a cell never written since reset or reinit reads as its initial value.
// ----------------------------------------------------------------------------
module srq_cell_store (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  srq_pkg::t_cell_rd i_rd,
    input  srq_pkg::t_cell_wr i_wr,
    input  logic             i_clear,
    output srq_pkg::t_cell   o_cell
);
    import srq_pkg::*;

    logic [MAX_DEPTH-1:0] r_valid;
    logic                 r_rd_valid;
    logic [ADDR_W-1:0]    r_rd_addr;
    logic [SEQ_W-1:0]     seq_q;
    logic [DATA_W-1:0]    data_q;

    srq_ram #(.WIDTH(SEQ_W), .DEPTH(MAX_DEPTH)) u_seq_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr.en),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wr.seq),
        .i_re    (i_rd.en),
        .i_raddr (i_rd.addr),
        .o_rdata (seq_q)
    );

    srq_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DEPTH)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr.en),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wr.data),
        .i_re    (i_rd.en),
        .i_raddr (i_rd.addr),
        .o_rdata (data_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    // sample the valid bit alongside the memory read
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_valid <= r_valid[i_rd.addr];
            r_rd_addr  <= i_rd.addr;
        end
    end

    assign o_cell.seq  = r_rd_valid ? seq_q  : SEQ_W'(r_rd_addr);
    assign o_cell.data = r_rd_valid ? data_q : '0;

endmodule

@@ tb/tb_sequenced_ring_queue_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sequenced_ring_queue_core
// Self-checking bench for the sequenced ring queue core.
// Drive push, pop, reinitialize and close requests into the input stream with
// random gaps and let the result stream stall at random. Track the ring cells,
// positions and open state alongside the block, and compare every response
// transaction field by field against the value tracked here.
// ----------------------------------------------------------------------------
module tb_sequenced_ring_queue_core;

    import srq_pkg::*;

    // one expected response transaction
    typedef struct {
        t_status           status;
        logic [DATA_W-1:0] word;
        logic [CNT_W-1:0]  length;
        logic              full;
    } t_reply;

    // ------------------------------------------------------------------------
    // Ring state mirror plus the queue of replies still owed by the block.
    // ------------------------------------------------------------------------
    class queue_result_tracker;
        logic [DATA_W-1:0] cell_word [MAX_DEPTH];
        logic [SEQ_W-1:0]  cell_seq  [MAX_DEPTH];
        logic [SEQ_W-1:0]  wr_pos;
        logic [SEQ_W-1:0]  rd_pos;
        int unsigned       held;
        int unsigned       depth;
        int unsigned       depth_request;
        bit                is_open;
        t_reply            expected_replies [$];
        int                errors;

        function new();
            errors        = 0;
            depth_request = CAP_RESET;
            reopen();
        endfunction

        // round the request up to a power of two, never above the cap
        function int unsigned rounded_depth(int unsigned req);
            int unsigned p;
            p = 1;
            while (p < req && p < CAP_LIMIT) p = p << 1;
            return p;
        endfunction

        function void reopen();
            depth = rounded_depth(depth_request);
            for (int i = 0; i < MAX_DEPTH; i++) begin
                cell_word[i] = '0;
                cell_seq[i]  = SEQ_W'(i);
            end
            wr_pos  = '0;
            rd_pos  = '0;
            held    = 0;
            is_open = 1'b1;
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("[%0t] MISMATCH %s", $realtime, what);
        endtask

        // advance the ring for one accepted request and queue its reply
        function void note_request(t_func fn, logic [DATA_W-1:0] word);
            t_reply            r;
            logic [SEQ_W-1:0]  mask;
            logic [ADDR_W-1:0] slot;
            r.status = ST_OK;
            r.word   = '0;
            mask     = SEQ_W'(depth) - 1;
            case (fn)
                FN_ENQ: begin
                    if (!is_open) begin
                        r.status = ST_INVALID;
                    end else begin
                        slot = ADDR_W'(wr_pos & mask);
                        // a cell whose sequence is off the write position counts as full
                        if (cell_seq[slot] != wr_pos) begin
                            r.status = ST_FULL;
                        end else begin
                            cell_word[slot] = word;
                            cell_seq[slot]  = wr_pos + 1;
                            wr_pos          = wr_pos + 1;
                            held++;
                        end
                    end
                end
                FN_DEQ: begin
                    if (!is_open) begin
                        r.status = ST_DISCONNECTED;
                    end else begin
                        slot = ADDR_W'(rd_pos & mask);
                        if (cell_seq[slot] != rd_pos + 1) begin
                            r.status = ST_EMPTY;
                        end else begin
                            r.word         = cell_word[slot];
                            cell_seq[slot] = rd_pos + SEQ_W'(depth);
                            rd_pos         = rd_pos + 1;
                            held--;
                        end
                    end
                end
                FN_REINIT: reopen();
                default: begin
                    // close keeps cells and positions, drops the count
                    is_open = 1'b0;
                    held    = 0;
                end
            endcase
            r.length = CNT_W'(held);
            r.full   = (held >= depth);
            expected_replies.push_back(r);
        endfunction

        task check_reply(logic [STATUS_W-1:0] status, logic [DATA_W-1:0] word,
                         logic [CNT_W-1:0] length, logic full);
            t_reply r;
            if (expected_replies.size() == 0) begin
                report_mismatch($sformatf("unexpected result status=%0d", status));
                return;
            end
            r = expected_replies.pop_front();
            if (status !== r.status)
                report_mismatch($sformatf("status got %0d exp %0d", status, r.status));
            if (word !== r.word)
                report_mismatch($sformatf("data_out got %h exp %h", word, r.word));
            if (length !== r.length)
                report_mismatch($sformatf("length got %0d exp %0d", length, r.length));
            if (full !== r.full)
                report_mismatch($sformatf("is_full got %b exp %b", full, r.full));
        endtask

        task flag_leftovers();
            if (expected_replies.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", expected_replies.size()));
        endtask
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CAP_W-1:0]       i_cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [DATA_W-1:0]      s_axis_tdata;       // [63:0] data_in
    logic [FUNC_W-1:0]      s_axis_tuser;       // [1:0] func
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;       // [63:0] data_out, [70:64] length, [71] is_full
    logic [STATUS_W-1:0]    m_axis_tuser;       // [2:0] status

    queue_result_tracker tracker = new();

    bit no_idle = 1'b0;          // set for stretches with no random gaps on either side
    int replies_seen = 0;

    sequenced_ring_queue_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // hard stop in case a handshake never completes
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Input side: one request per call, all changes at the falling edge.
    // ------------------------------------------------------------------------
    task automatic send_request(t_func fn, logic [DATA_W-1:0] word);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = word;
        s_axis_tuser  = fn;
        // hold the transaction until the block takes it
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_request(fn, word);
    endtask

    // drop valid and wait until every owed result has come back
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    // write the capacity request; it only takes effect at the next reinitialize
    task automatic write_capacity(logic [CAP_W-1:0] req);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = req;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        tracker.depth_request = req;
    endtask

    function automatic logic [DATA_W-1:0] random_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // random traffic at one capacity; push_pct steers toward full or empty
    task automatic run_phase(logic [CAP_W-1:0] req, int n, int push_pct);
        int pick;
        drain();
        write_capacity(req);
        send_request(FN_REINIT, random_word());
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < push_pct)  send_request(FN_ENQ, random_word());
            else if (pick < 97)   send_request(FN_DEQ, random_word());
            else if (pick < 98)   send_request(FN_CLOSE, random_word());
            else                  send_request(FN_REINIT, random_word());
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stalls, plus a long hold-off now and then so the
    // block backs up and stalls its input.
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (replies_seen % 300 == 120) gap = 80;
            else if (no_idle)              gap = 0;
            else                           gap = $urandom_range(0, 3);
            repeat (gap) begin
                @(negedge i_clk);
                m_axis_tready = 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            tracker.check_reply(m_axis_tuser, m_axis_tdata[63:0], m_axis_tdata[70:64],
                                m_axis_tdata[71]);
            replies_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FN_ENQ;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset queue of depth 64: empty pop, data extremes, drain past empty
        send_request(FN_DEQ, '1);
        send_request(FN_ENQ, '0);
        send_request(FN_ENQ, '1);
        send_request(FN_ENQ, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(FN_ENQ, 64'h5555_5555_5555_5555);
        send_request(FN_DEQ, '0);
        send_request(FN_DEQ, '0);
        send_request(FN_DEQ, '0);
        send_request(FN_DEQ, '0);
        send_request(FN_DEQ, '0);

        // depth 2: fill to full, refuse, wrap around the ring
        drain();
        write_capacity(CAP_W'(2));
        send_request(FN_REINIT, '0);
        send_request(FN_ENQ, 64'h0123_4567_89AB_CDEF);
        send_request(FN_ENQ, 64'hFEDC_BA98_7654_3210);
        send_request(FN_ENQ, 64'h8000_0000_0000_0001);
        send_request(FN_DEQ, '0);
        send_request(FN_ENQ, 64'h0000_0000_FFFF_FFFF);
        send_request(FN_ENQ, 64'hFFFF_FFFF_0000_0000);

        // close twice, then push and pop on a dead queue, then reopen
        send_request(FN_CLOSE, '0);
        send_request(FN_CLOSE, '1);
        send_request(FN_ENQ, 64'h1);
        send_request(FN_DEQ, '0);
        send_request(FN_REINIT, '0);
        send_request(FN_DEQ, '0);

        // random traffic over several depths, the extremes among them
        run_phase(CAP_W'(0),   60, 55);
        run_phase(CAP_W'(1),   80, 50);
        no_idle = 1'b1;
        run_phase(CAP_W'(64), 140, 80);
        no_idle = 1'b0;
        run_phase(CAP_W'(127), 90, 30);
        run_phase(CAP_W'(5),  100, 60);
        run_phase(CAP_W'(33), 120, 75);
        no_idle = 1'b1;
        run_phase(CAP_W'($urandom_range(1, 64)), 100, 55);
        no_idle = 1'b0;
        run_phase(CAP_W'(16), 110, 65);
        run_phase(CAP_W'($urandom_range(0, 127)), 80, 50);

        drain();
        repeat (20) @(posedge i_clk);
        tracker.flag_leftovers();
        if (tracker.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/srq_pkg.sv
src/srq_ram.sv
src/srq_cell_store.sv
src/sequenced_ring_queue_core.sv
tb/tb_sequenced_ring_queue_core.sv
